/* hw/rtl/kmwu_pkg.sv */
package kmwu_pkg;

  // Transaction codes
  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_WALL    = 1'b1;

  // Register select, taken from paddr[2]
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam int CFG_W   = 6;
  localparam int COORD_W = 5;
  localparam int DIM_W   = 9;   // holds any grid size up to 256

  localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;

  // Control from the sequencer to the label ring
  typedef struct packed {
    logic shift;     // every cell takes its neighbour's label
    logic restart;   // every cell reloads its own index
    logic merge;     // feedback rewrites the old label with the new one
  } ring_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIND = 4'b0010,
    S_JOIN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

/* hw/rtl/kruskal_maze_wall_union.sv */
// Channel   Signals                                   Direction
// input     in_valid/in_ready: mode horizontal col row  in
// output    out_valid/out_ready: removed status         out
// config    psel penable pwrite paddr pwdata prdata     APB, 2 registers
//
// The ring holds N = MAX_WIDTH*MAX_HEIGHT cells. A restart or out-of-range
// wall goes straight to the result. A wall with equal labels takes one ring
// pass; a wall that joins two sets takes two. The ring moves every cell past
// its head once per pass: one pass to read both labels, one pass to relabel.
// Reset is synchronous; every cell loads its own index in that cycle.
// A new transaction is taken while a result waits in the output register.
module kruskal_maze_wall_union
  import kmwu_pkg::*;
#(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic               horizontal,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               removed,
  output logic               status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int LW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [LW-1:0] LAST = LW'(CELLS - 1);

  state_t            state;
  logic [CFG_W-1:0]  grid_width;
  logic [CFG_W-1:0]  grid_height;
  logic [LW-1:0]     cnt;
  logic [LW-1:0]     ia, ib, la, lb;
  logic [LW-1:0]     la_v, lb_v, head;
  logic              res_removed, res_status;
  logic              in_accept, cfg_write, out_free;
  logic [DIM_W-1:0]  w_lim, h_lim, x9, y9;
  logic              wall_ok;
  logic [COORD_W-1:0] xb, yb;
  ring_ctrl_t        ctrl;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {26'b0, (paddr[2] == REG_GRID_HEIGHT) ? grid_height : grid_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_GRID_WIDTH) begin
        grid_width <= pwdata[CFG_W-1:0];
      end else begin
        grid_height <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Wall range check against clamped grid size
  assign w_lim = ({3'b0, grid_width} > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                         : {3'b0, grid_width};
  assign h_lim = ({3'b0, grid_height} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : {3'b0, grid_height};
  assign x9 = {4'b0, col};
  assign y9 = {4'b0, row};
  assign wall_ok = horizontal ? (x9 < w_lim && y9 != '0 && y9 < h_lim)
                              : (x9 != '0 && x9 < w_lim && y9 < h_lim);
  assign xb = horizontal ? col : col - 5'd1;
  assign yb = horizontal ? row - 5'd1 : row;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Labels seen at the head this cycle
  assign la_v = (cnt == ia) ? head : la;
  assign lb_v = (cnt == ib) ? head : lb;

  // Ring control
  always_comb begin
    ctrl.shift   = (state == S_FIND) || (state == S_JOIN);
    ctrl.restart = in_accept && (mode == MODE_RESTART);
    ctrl.merge   = (state == S_JOIN);
  end

  kmwu_ring #(
    .CELLS (CELLS),
    .LW    (LW)
  ) u_ring (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .la   (la),
    .lb   (lb),
    .head (head)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            cnt   <= '0;
            state <= (mode == MODE_WALL && wall_ok) ? S_FIND : S_DONE;
          end
        end
        S_FIND: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= (la_v != lb_v) ? S_JOIN : S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_JOIN: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

  // Indices, captured labels and pending result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ia          <= LW'(col) + LW'(row) * LW'(MAX_WIDTH);
      ib          <= LW'(xb) + LW'(yb) * LW'(MAX_WIDTH);
      res_removed <= 1'b0;
      res_status  <= (mode == MODE_WALL) && !wall_ok;
    end
    if (state == S_FIND) begin
      la <= la_v;
      lb <= lb_v;
    end
    if (state == S_JOIN && cnt == LAST) begin
      res_removed <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      removed <= res_removed;
      status  <= res_status;
    end
  end

  // Checks
  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> cnt == '0)
    else $error("counter not cleared in idle");

  a_join_diff: assert property (@(posedge clk) disable iff (rst)
    state == S_JOIN |-> la != lb)
    else $error("relabel pass with equal labels");

  a_find_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND && cnt == LAST) |=>
      ((state == S_JOIN) == ($past(la_v) != $past(lb_v))))
    else $error("wrong decision after label search");

  a_result_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(removed && status))
    else $error("out-of-range wall reported removed");

endmodule

/* hw/rtl/kmwu_cell.sv */
module kmwu_cell
  import kmwu_pkg::*;
#(
  parameter int LW    = 10,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  ring_ctrl_t    ctrl,
  input  logic [LW-1:0] next_label,
  output logic [LW-1:0] label
);

  // One label slot: reload own index, or take the neighbour's label
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      label <= LW'(INDEX);
    end else if (ctrl.shift) begin
      label <= next_label;
    end
  end

endmodule

/* hw/rtl/kmwu_ring.sv */
module kmwu_ring
  import kmwu_pkg::*;
#(
  parameter int CELLS = 1024,
  parameter int LW    = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  ring_ctrl_t    ctrl,
  input  logic [LW-1:0] la,
  input  logic [LW-1:0] lb,
  output logic [LW-1:0] head
);

  logic [LW-1:0] lbl [CELLS];
  logic [LW-1:0] feedback;

  // Head label re-enters at the tail; during a merge the old set label
  // is swapped for the new one on its way round
  assign head     = lbl[0];
  assign feedback = (ctrl.merge && (lbl[0] == lb)) ? la : lbl[0];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic [LW-1:0] nxt;
    if (i == CELLS - 1) begin : g_tail
      assign nxt = feedback;
    end else begin : g_body
      assign nxt = lbl[i+1];
    end
    kmwu_cell #(
      .LW    (LW),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .next_label (nxt),
      .label      (lbl[i])
    );
  end

endmodule
